// ----- src/scfl_pkg.sv -----
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared constants, codes and types for the set-associative FIFO cache lookup.
// ----------------------------------------------------------------------------
package scfl_pkg;

  localparam int NUM_SETS = 32;
  localparam int NUM_WAYS = 8;

  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int SET_IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_IDX_W = ($clog2(NUM_WAYS) > 0) ? $clog2(NUM_WAYS) : 1;
  localparam int WCNT_W    = $clog2(NUM_WAYS + 1);

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int OUT_WAY_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [3:0] LINE_SHIFT_RST  = 4'd6;
  localparam logic [2:0] SET_SHIFT_RST   = 3'd5;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_SHIFT  = 2'd0,
    CFG_SET_SHIFT   = 2'd1,
    CFG_WAYS_IN_USE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
  } scfl_cmd_t;

endpackage

// ----- src/scfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// scfl_ctrl
// Sequencer: a capture step with tag read, then a lookup and update step.
// ----------------------------------------------------------------------------
module scfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output scfl_pkg::scfl_cmd_t cmd
);
  import scfl_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.lookup;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    busy        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy       = 1'b1;
        cmd.lookup = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start lookup");
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("transaction result missing");
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.lookup))
    else $error("capture and lookup together");
`endif

endmodule

// ----- src/scfl_datapath.sv -----
// ----------------------------------------------------------------------------
// scfl_datapath
// Config registers, tag store, valid bits, victim pointers, hit/miss counters.
// ----------------------------------------------------------------------------
module scfl_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  scfl_pkg::scfl_cmd_t               cmd,
  input  logic                              cfg_write,
  input  logic [scfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scfl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [scfl_pkg::ADDR_W-1:0]       address,
  output logic                              is_hit,
  output logic [scfl_pkg::OUT_WAY_W-1:0]    way_used,
  output logic                              evicted,
  output logic [scfl_pkg::ADDR_W-1:0]       evicted_line_address,
  output logic [scfl_pkg::CNT_W-1:0]        hits_so_far,
  output logic [scfl_pkg::CNT_W-1:0]        misses_so_far
);
  import scfl_pkg::*;

  logic [3:0] line_shift;
  logic [2:0] set_shift;
  logic [3:0] ways_in_use;

  logic [ADDR_W-1:0]    tag_mem [NUM_WAYS][NUM_SETS];
  logic [ADDR_W-1:0]    rd_tag  [NUM_WAYS];
  logic [NUM_WAYS-1:0]  valid   [NUM_SETS];
  logic [WAY_IDX_W-1:0] vptr    [NUM_SETS];

  logic [SET_IDX_W-1:0] set_q;
  logic [ADDR_W-1:0]    lstart_q;

  logic [2:0]           set_eff;
  logic [SET_IDX_W:0]   mask_wide;
  logic [SET_IDX_W-1:0] set_mask;
  logic [ADDR_W-1:0]    shifted;
  logic [SET_IDX_W-1:0] set_in;
  logic [ADDR_W-1:0]    lmask;
  logic [ADDR_W-1:0]    lstart_in;
  logic [WCNT_W-1:0]    ways_eff;

  logic [NUM_WAYS-1:0]  row_valid;
  logic                 found;
  logic                 hit;
  logic [WAY_IDX_W-1:0] first_way;
  logic [WAY_IDX_W-1:0] vp;
  logic [WAY_IDX_W-1:0] vp_next;
  logic [WAY_IDX_W-1:0] wr_way;
  logic                 wr_en;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      line_shift  <= LINE_SHIFT_RST;
      set_shift   <= SET_SHIFT_RST;
      ways_in_use <= WAYS_IN_USE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LINE_SHIFT:  line_shift  <= cfg_data[3:0];
        CFG_SET_SHIFT:   set_shift   <= cfg_data[2:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    set_eff   = (int'(set_shift) > SET_BITS) ? 3'(SET_BITS) : set_shift;
    mask_wide = ((SET_IDX_W+1)'(1) << set_eff) - (SET_IDX_W+1)'(1);
    set_mask  = mask_wide[SET_IDX_W-1:0];
    shifted   = address >> line_shift;
    set_in    = shifted[SET_IDX_W-1:0] & set_mask;
    lmask     = ~((ADDR_W'(1) << line_shift) - ADDR_W'(1));
    lstart_in = address & lmask;
    if (ways_in_use == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_in_use) > NUM_WAYS) begin
      ways_eff = WCNT_W'(NUM_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q    <= set_in;
      lstart_q <= lstart_in;
    end
  end

  // tag store: all ways read at one set, one way written
  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (cmd.capture) begin
        rd_tag[w] <= tag_mem[w][set_in];
      end
      if (wr_en && wr_way == WAY_IDX_W'(w)) begin
        tag_mem[w][set_q] <= lstart_q;
      end
    end
  end

  // way selection
  always_comb begin
    row_valid = valid[set_q];
    found     = 1'b0;
    hit       = 1'b0;
    first_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && w < int'(ways_eff)) begin
        if (!row_valid[w] || rd_tag[w] == lstart_q) begin
          found     = 1'b1;
          hit       = row_valid[w];
          first_way = WAY_IDX_W'(w);
        end
      end
    end
    vp      = (int'(vptr[set_q]) >= int'(ways_eff)) ? '0 : vptr[set_q];
    vp_next = (int'(vp) + 1 >= int'(ways_eff)) ? '0 : vp + WAY_IDX_W'(1);
    wr_way  = found ? first_way : vp;
    wr_en   = cmd.lookup && !hit;
  end

  // valid bits, victim pointers, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid[s] <= '0;
        vptr[s]  <= '0;
      end
      hits_so_far   <= '0;
      misses_so_far <= '0;
    end else if (cmd.lookup) begin
      if (hit) begin
        if (hits_so_far != '1) begin
          hits_so_far <= hits_so_far + CNT_W'(1);
        end
      end else begin
        valid[set_q][wr_way] <= 1'b1;
        if (!found) begin
          vptr[set_q] <= vp_next;
        end
        if (misses_so_far != '1) begin
          misses_so_far <= misses_so_far + CNT_W'(1);
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      is_hit               <= hit;
      way_used             <= OUT_WAY_W'(wr_way);
      evicted              <= !found;
      evicted_line_address <= found ? '0 : rd_tag[vp];
    end
  end

`ifndef NO_ASSERTIONS
  a_hits_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hits_so_far >= $past(hits_so_far))
    else $error("hit count went down");
  a_miss_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> misses_so_far >= $past(misses_so_far))
    else $error("miss count went down");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.lookup |=> $stable(hits_so_far) && $stable(misses_so_far))
    else $error("counter moved outside lookup");
`endif

endmodule

// ----- src/set_assoc_cache_fifo_lookup_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup_core
// Set-associative read cache lookup with FIFO replacement and hit/miss counts.
//
//   channel   handshake                  payload
//   request   start, busy                address
//   result    done (one-cycle strobe)    is_hit, way_used, evicted,
//                                        evicted_line_address, hits_so_far,
//                                        misses_so_far
//   config    cfg_write                  cfg_index, cfg_data
//
// In a transaction the tag store row is read in the accept cycle and compared
// and updated in the next; no new start is taken while busy in the lookup.
// The result strobes in the cycle after the lookup, alongside the next accept.
// Reset clears valid bits, victim pointers and counters at once; no sweep.
// The receiver cannot stall; the done strobe marks each result for one cycle only.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_lookup_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [scfl_pkg::ADDR_W-1:0]       address,
  output logic                              done,
  output logic                              is_hit,
  output logic [scfl_pkg::OUT_WAY_W-1:0]    way_used,
  output logic                              evicted,
  output logic [scfl_pkg::ADDR_W-1:0]       evicted_line_address,
  output logic [scfl_pkg::CNT_W-1:0]        hits_so_far,
  output logic [scfl_pkg::CNT_W-1:0]        misses_so_far,
  input  logic                              cfg_write,
  input  logic [scfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scfl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scfl_pkg::*;

  scfl_cmd_t cmd;

  scfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  scfl_datapath u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .cfg_write            (cfg_write),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .address              (address),
    .is_hit               (is_hit),
    .way_used             (way_used),
    .evicted              (evicted),
    .evicted_line_address (evicted_line_address),
    .hits_so_far          (hits_so_far),
    .misses_so_far        (misses_so_far)
  );

endmodule
